>>> rtl/core/assert_macros.svh
// Assertion shorthands shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LSW_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lap_stopwatch: assertion failed");

// Next-cycle implication.
`define LSW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lap_stopwatch: assertion failed");

`endif

>>> rtl/core/lsw_pkg.sv
package lsw_pkg;

	localparam logic [2:0] OP_UPDATE  = 3'd0;
	localparam logic [2:0] OP_NEW_LAP = 3'd1;
	localparam logic [2:0] OP_RESET   = 3'd2;
	localparam logic [2:0] OP_INIT    = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;

	// Reciprocal constants for exact division of unsigned values.
	// x / 100 for any 32-bit x
	localparam logic [31:0] DIV100_MUL   = 32'd1374389535;
	localparam int          DIV100_SHIFT = 37;
	// x / 10 for any 32-bit x
	localparam logic [31:0] DIV10_MUL    = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT  = 35;
	// x / 60 for x below 2^24
	localparam logic [23:0] DIV60_MUL    = 24'd8947849;
	localparam int          DIV60_SHIFT  = 29;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] now_ms;
		logic [3:0]  lap_index;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  cur_tenths;
		logic [5:0]  cur_seconds;
		logic [16:0] cur_minutes;
		logic [4:0]  lap_count;
		logic [3:0]  total_tenths;
		logic [5:0]  total_seconds;
		logic [5:0]  total_minutes;
		logic [10:0] total_hours;
		logic [3:0]  lap_tenths;
		logic [5:0]  lap_seconds;
		logic [16:0] lap_minutes;
	} out_item_t;

endpackage

>>> rtl/core/lsw_ifs.sv
interface lsw_in_if;
	import lsw_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface lsw_out_if;
	import lsw_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/lsw_split.sv
// Four-stage split of a millisecond count into tenths, seconds, minutes and hours.
module lsw_split (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] value,
	output logic [3:0]  tenths,
	output logic [5:0]  seconds,
	output logic [16:0] minutes,
	output logic [5:0]  min_in_hour,
	output logic [10:0] hours
);
	import lsw_pkg::*;

	logic [63:0] p100;
	logic [57:0] p10;
	logic [46:0] p60a;
	logic [40:0] p60b;
	logic [22:0] q1000;
	logic [25:0] rem10;
	logic [16:0] mins;
	logic [22:0] rem60a;
	logic [10:0] hrs;
	logic [16:0] rem60b;

	logic [25:0] q100_s1;
	logic [22:0] q1000_s2;
	logic [3:0]  tenths_s2, tenths_s3, tenths_s4;
	logic [16:0] mins_s3, mins_s4;
	logic [5:0]  secs_s3, secs_s4;
	logic [5:0]  mih_s4;
	logic [10:0] hrs_s4;

	assign p100  = 64'(value) * 64'(DIV100_MUL);
	assign p10   = 58'(q100_s1) * 58'(DIV10_MUL);
	assign q1000 = p10[DIV10_SHIFT +: 23];
	assign rem10 = q100_s1 - ({3'b000, q1000} * 26'd10);

	assign p60a   = 47'(q1000_s2) * 47'(DIV60_MUL);
	assign mins   = p60a[DIV60_SHIFT +: 17];
	assign rem60a = q1000_s2 - ({6'd0, mins} * 23'd60);

	assign p60b   = 41'(mins_s3) * 41'(DIV60_MUL);
	assign hrs    = p60b[DIV60_SHIFT +: 11];
	assign rem60b = mins_s3 - ({6'd0, hrs} * 17'd60);

	always_ff @(posedge clk) begin
		if (en) begin
			q100_s1   <= p100[DIV100_SHIFT +: 26];
			q1000_s2  <= q1000;
			tenths_s2 <= rem10[3:0];
			mins_s3   <= mins;
			secs_s3   <= rem60a[5:0];
			tenths_s3 <= tenths_s2;
			hrs_s4    <= hrs;
			mih_s4    <= rem60b[5:0];
			mins_s4   <= mins_s3;
			secs_s4   <= secs_s3;
			tenths_s4 <= tenths_s3;
		end
	end

	assign tenths      = tenths_s4;
	assign seconds     = secs_s4;
	assign minutes     = mins_s4;
	assign min_in_hour = mih_s4;
	assign hours       = hrs_s4;

endmodule

>>> rtl/core/lap_stopwatch_top.sv
// Lap stopwatch. Each beat on req carries an op (update, new lap, reset, init, read lap),
// a free-running millisecond tick and a lap index; exactly one beat leaves on rsp for each,
// in order, behind the split pipeline. One beat is taken per cycle for as long as rsp
// keeps up: the state update for an op settles in the cycle it is accepted, and the display
// split behind it is a four-stage pipeline of reciprocal multiplies (divide by 100, by 10,
// by 60, by 60), so the rate is set by nothing but backpressure on rsp. The lap table holds
// LAP_SLOTS raw lap times; a flip-flop per slot marks it written, so the table reads as zero
// straight after reset or a reset op and needs no clearing pass. New lap with a full table
// still adds to the total and restarts the lap but records nothing. Read lap beyond the table
// returns zeros; every other op returns zeros in the lap fields. Hours of the total are whole
// hours of the accumulated milliseconds; minutes of the total wrap at sixty.
`include "assert_macros.svh"

module lap_stopwatch_top #(
	parameter int LAP_SLOTS = 16
) (
	input logic        clk,
	input logic        arst_n,
	lsw_in_if.sink     req,
	lsw_out_if.source  rsp
);
	import lsw_pkg::*;

	localparam int AW = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
	localparam int CW = $clog2(LAP_SLOTS + 1);

	// Pipeline control: every stage advances together unless the result is stalled.
	logic en;
	logic acc;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// Architectural state, updated on the accepting edge.
	logic [31:0]          lap_start_q;
	logic [31:0]          elapsed_q;
	logic [31:0]          cur_raw_q;   // elapsed as displayed: zero after init
	logic [31:0]          total_q;
	logic [CW-1:0]        laps_q;
	logic [LAP_SLOTS-1:0] slot_vld_q;

	// Lap table: raw millisecond lap times.
	logic [31:0] lap_mem [LAP_SLOTS];
	logic [31:0] rd_raw_s1;
	logic        rd_hit_s1;

	logic [AW+3:0]    idx_ext;
	logic [AW+CW-1:0] laps_ext;
	logic [CW+4:0]    cnt_ext;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic             rd_in_range;
	logic             table_free;
	logic             wr_en;
	logic [31:0]      lap_val;

	logic [4:0] cnt_s2, cnt_s3, cnt_s4, cnt_s5;

	assign en        = !vld_s5 || rsp.ready;
	assign acc       = req.valid && en;
	assign req.ready = en;

	assign idx_ext     = {{AW{1'b0}}, req.data.lap_index};
	assign rd_addr     = idx_ext[AW-1:0];
	assign rd_in_range = idx_ext < (AW + 4)'(LAP_SLOTS);

	assign laps_ext   = {{AW{1'b0}}, laps_q};
	assign wr_addr    = laps_ext[AW-1:0];
	assign table_free = laps_q < CW'(LAP_SLOTS);
	assign wr_en      = acc && (req.data.op == OP_NEW_LAP) && table_free;

	assign cnt_ext = {5'd0, laps_q};

	// State update: one op per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lap_start_q <= '0;
			elapsed_q   <= '0;
			cur_raw_q   <= '0;
			total_q     <= '0;
			laps_q      <= '0;
			slot_vld_q  <= '0;
		end else if (acc) begin
			case (req.data.op)
				OP_UPDATE: begin
					elapsed_q <= req.data.now_ms - lap_start_q;
					cur_raw_q <= req.data.now_ms - lap_start_q;
				end
				OP_NEW_LAP: begin
					total_q     <= total_q + elapsed_q;
					lap_start_q <= req.data.now_ms;
					if (table_free) begin
						laps_q              <= CW'(laps_q + 1'b1);
						slot_vld_q[wr_addr] <= 1'b1;
					end
				end
				OP_RESET: begin
					lap_start_q <= req.data.now_ms;
					total_q     <= '0;
					laps_q      <= '0;
					slot_vld_q  <= '0;
				end
				OP_INIT: begin
					cur_raw_q   <= '0;
					lap_start_q <= req.data.now_ms;
				end
				default: begin
				end
			endcase
		end
	end

	// Table write and registered read; ops are exclusive, so never both at once.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lap_mem[wr_addr] <= cur_raw_q;
		end
		if (acc && (req.data.op == OP_READ)) begin
			rd_raw_s1 <= lap_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Hit only for read lap on a written slot in range; anything else shows zeros.
	always_ff @(posedge clk) begin
		if (en) begin
			rd_hit_s1 <= acc && (req.data.op == OP_READ) && rd_in_range
				&& slot_vld_q[rd_addr];
			cnt_s2    <= cnt_ext[4:0];
			cnt_s3    <= cnt_s2;
			cnt_s4    <= cnt_s3;
			cnt_s5    <= cnt_s4;
		end
	end

	assign lap_val = rd_hit_s1 ? rd_raw_s1 : 32'd0;

	// Display split: three lanes, same latency.
	lsw_split u_cur_split (
		.clk         (clk),
		.en          (en),
		.value       (cur_raw_q),
		.tenths      (rsp.data.cur_tenths),
		.seconds     (rsp.data.cur_seconds),
		.minutes     (rsp.data.cur_minutes),
		.min_in_hour (),
		.hours       ()
	);

	lsw_split u_total_split (
		.clk         (clk),
		.en          (en),
		.value       (total_q),
		.tenths      (rsp.data.total_tenths),
		.seconds     (rsp.data.total_seconds),
		.minutes     (),
		.min_in_hour (rsp.data.total_minutes),
		.hours       (rsp.data.total_hours)
	);

	lsw_split u_lap_split (
		.clk         (clk),
		.en          (en),
		.value       (lap_val),
		.tenths      (rsp.data.lap_tenths),
		.seconds     (rsp.data.lap_seconds),
		.minutes     (rsp.data.lap_minutes),
		.min_in_hour (),
		.hours       ()
	);

	assign rsp.data.lap_count = cnt_s5;
	assign rsp.valid          = vld_s5;

	// Written slots always form the prefix counted by the lap counter.
	`LSW_ASSERT_SAME(a_slots_match_count, 1'b1, $countones(slot_vld_q) == int'(laps_q))
	`LSW_ASSERT_SAME(a_count_bounded, 1'b1, laps_q <= CW'(LAP_SLOTS))
	`LSW_ASSERT_NEXT(a_reset_clears, acc && (req.data.op == OP_RESET), laps_q == '0 && total_q == '0)
	`LSW_ASSERT_NEXT(a_lap_advances, wr_en, laps_q == CW'($past(laps_q) + 1'b1))

endmodule

>>> tb/tb_lap_stopwatch_top.sv
module tb_lap_stopwatch_top;
	import lsw_pkg::*;

	// Spare op codes: the block must leave its state alone on these.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int LAP_SLOTS = 16;

	// Millisecond weights used to break a duration into display digits.
	localparam logic [31:0] MS_PER_TENTH  = 32'd100;
	localparam logic [31:0] MS_PER_SEC    = 32'd1000;
	localparam logic [31:0] MS_PER_MIN    = 32'd60000;
	localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
	localparam logic [31:0] SIXTY         = 32'd60;

	localparam int TOTAL_BEATS = 1550;
	// Run the tail of the stimulus with both sides flowing freely.
	localparam int CALM_FROM   = TOTAL_BEATS - 150;
	// Response pipeline is five deep; leave a little margin on top.
	localparam int DRAIN_PAD   = 20;
	localparam int PLAN_ROWS   = 15;

	localparam out_item_t ZERO_DISP = '0;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] now;
		logic [3:0]  idx;
		int          reps;
		bit          typed;
		out_item_t   disp;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	lsw_in_if  req_if ();
	lsw_out_if rsp_if ();

	lap_stopwatch_top #(
		.LAP_SLOTS(LAP_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// Free-running clock, period 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the stopwatch state, advanced once per accepted request beat.
	logic [31:0] lap_origin    = '0;
	logic [31:0] held_elapsed  = '0;
	logic [3:0]  split_tenths  = '0;
	logic [5:0]  split_secs    = '0;
	logic [16:0] split_mins    = '0;
	logic [4:0]  laps_logged   = '0;
	logic [26:0] lap_book [LAP_SLOTS];
	logic [31:0] run_total     = '0;

	out_item_t owed_displays [$];
	bit        row_typed;
	out_item_t row_disp;

	int fault_cnt     = 0;
	int fed_beats     = 0;
	int checked_beats = 0;
	int full_hits     = 0;
	int src_pct       = 0;
	int snk_pct       = 0;
	int snk_hold      = 0;

	// Apply one op to the shadow state and return the display the block should show.
	function automatic out_item_t advance_watch(in_item_t beat);
		out_item_t   disp;
		logic [26:0] pick;
		pick = '0;
		case (beat.op)
			OP_UPDATE: begin
				// Measure from the lap start; wrap of the tick counter falls out of the subtraction.
				held_elapsed = beat.now_ms - lap_origin;
				split_tenths = 4'((held_elapsed % MS_PER_SEC) / MS_PER_TENTH);
				split_secs   = 6'((held_elapsed / MS_PER_SEC) % SIXTY);
				split_mins   = 17'(held_elapsed / MS_PER_MIN);
			end
			OP_NEW_LAP: begin
				// Add the last measured time, not a fresh one.
				run_total = run_total + held_elapsed;
				if (laps_logged < LAP_SLOTS) begin
					lap_book[laps_logged] = {split_mins, split_secs, split_tenths};
					laps_logged = laps_logged + 5'd1;
				end else begin
					full_hits++;
				end
				lap_origin = beat.now_ms;
			end
			OP_RESET: begin
				// Keep the elapsed time and the current split.
				lap_origin = beat.now_ms;
				foreach (lap_book[k])
					lap_book[k] = '0;
				run_total   = '0;
				laps_logged = '0;
			end
			OP_INIT: begin
				split_tenths = '0;
				split_secs   = '0;
				split_mins   = '0;
				lap_origin   = beat.now_ms;
			end
			OP_READ: begin
				if (beat.lap_index < LAP_SLOTS)
					pick = lap_book[beat.lap_index];
			end
			default: ;
		endcase
		disp.cur_tenths    = split_tenths;
		disp.cur_seconds   = split_secs;
		disp.cur_minutes   = split_mins;
		disp.lap_count     = laps_logged;
		disp.total_tenths  = 4'((run_total % MS_PER_SEC) / MS_PER_TENTH);
		disp.total_seconds = 6'((run_total / MS_PER_SEC) % SIXTY);
		disp.total_minutes = 6'((run_total / MS_PER_MIN) % SIXTY);
		disp.total_hours   = 11'(run_total / MS_PER_HOUR);
		disp.lap_tenths    = pick[3:0];
		disp.lap_seconds   = pick[9:4];
		disp.lap_minutes   = pick[26:10];
		return disp;
	endfunction

	task automatic match_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_cnt++;
		end
	endtask

	task automatic check_display(input out_item_t want, input out_item_t got);
		match_field("cur_tenths",    32'(want.cur_tenths),    32'(got.cur_tenths));
		match_field("cur_seconds",   32'(want.cur_seconds),   32'(got.cur_seconds));
		match_field("cur_minutes",   32'(want.cur_minutes),   32'(got.cur_minutes));
		match_field("lap_count",     32'(want.lap_count),     32'(got.lap_count));
		match_field("total_tenths",  32'(want.total_tenths),  32'(got.total_tenths));
		match_field("total_seconds", 32'(want.total_seconds), 32'(got.total_seconds));
		match_field("total_minutes", 32'(want.total_minutes), 32'(got.total_minutes));
		match_field("total_hours",   32'(want.total_hours),   32'(got.total_hours));
		match_field("lap_tenths",    32'(want.lap_tenths),    32'(got.lap_tenths));
		match_field("lap_seconds",   32'(want.lap_seconds),   32'(got.lap_seconds));
		match_field("lap_minutes",   32'(want.lap_minutes),   32'(got.lap_minutes));
		checked_beats++;
	endtask

	// Pick an idling rate for one side; a good share of sessions run with none.
	function automatic int pick_pace();
		case ($urandom_range(0, 4))
			0, 1:    return 0;
			2:       return 5;
			3:       return 20;
			default: return 40;
		endcase
	endfunction

	// Offer one request beat and hold it until the block takes it.
	// Optionally idle the valid line for a burst first.
	task automatic push_request(input logic [2:0] op, input logic [31:0] now,
			input logic [3:0] idx, input bit typed = 1'b0,
			input out_item_t disp = '0);
		in_item_t beat;
		beat.op        = op;
		beat.now_ms    = now;
		beat.lap_index = idx;
		if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= beat;
		row_typed    <= typed;
		row_disp     <= disp;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		if (op <= OP_READ)
			fed_beats++;
	endtask

	// Response side: stall the ready line in bursts of random length.
	always @(posedge clk) begin
		if (snk_hold == 0 && snk_pct != 0 && $urandom_range(0, 99) < snk_pct)
			snk_hold = $urandom_range(1, 12);
		if (snk_hold != 0) begin
			rsp_if.ready <= 1'b0;
			snk_hold--;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// Watch both channels. Queue the expected display when a request beat is taken,
	// then match any response beat against the oldest one still owed.
	// Rows with a hand-written display queue that instead of the shadow's guess,
	// though the shadow still advances so later rows line up.
	always @(posedge clk) begin : watch_ports
		out_item_t calc;
		if (arst_n && req_if.valid && req_if.ready) begin
			calc = advance_watch(req_if.data);
			owed_displays.push_back(row_typed ? row_disp : calc);
		end
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (owed_displays.size() == 0) begin
				$error("response beat arrived with nothing outstanding");
				fault_cnt++;
			end else begin
				check_display(owed_displays.pop_front(), rsp_if.data);
			end
		end
	end

	// Hard stop, well beyond the slowest legal run.
	initial begin
		#6000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		plan_row_t   plan [PLAN_ROWS];
		logic [31:0] tick;
		logic [31:0] step;
		int          kind;

		foreach (lap_book[k])
			lap_book[k] = '0;

		// Hold every input at a known value while reset is applied.
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		row_typed    = 1'b0;
		row_disp     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Displays are written out only where the digits are obvious:
		// straight after reset, and a full-scale tick which yields 71582 min 47.2 s.
		plan = '{
			// Fresh from reset: everything reads zero.
			'{OP_UPDATE,   32'd0,          4'd0,  1, 1'b1, ZERO_DISP},
			'{OP_READ,     32'd0,          4'd15, 1, 1'b1, ZERO_DISP},
			// Largest lap the counter can measure.
			'{OP_UPDATE,   32'hFFFF_FFFF,  4'd0,  1, 1'b1,
				out_item_t'{4'd2, 6'd47, 17'd71582, 5'd0,
					4'd0, 6'd0, 6'd0, 11'd0, 4'd0, 6'd0, 17'd0}},
			// Bank it: total is now the largest too, 1193 h 2 min 47.2 s.
			'{OP_NEW_LAP,  32'hFFFF_FFFF,  4'd0,  1, 1'b1,
				out_item_t'{4'd2, 6'd47, 17'd71582, 5'd1,
					4'd2, 6'd47, 6'd2, 11'd1193, 4'd0, 6'd0, 17'd0}},
			'{OP_READ,     32'd0,          4'd0,  1, 1'b1,
				out_item_t'{4'd2, 6'd47, 17'd71582, 5'd1,
					4'd2, 6'd47, 6'd2, 11'd1193, 4'd2, 6'd47, 17'd71582}},
			// Tick wraps past the lap start.
			'{OP_UPDATE,   32'd0,          4'd3,  1, 1'b0, ZERO_DISP},
			'{OP_NEW_LAP,  32'd0,          4'd9,  1, 1'b0, ZERO_DISP},
			// Init clears the split but leaves the measured time for the next lap.
			'{OP_INIT,     32'h8000_0000,  4'd7,  1, 1'b0, ZERO_DISP},
			'{OP_UPDATE,   32'h8036_EE7F,  4'd1,  1, 1'b0, ZERO_DISP},
			'{OP_SPARE_LO, 32'h5555_5555,  4'd10, 1, 1'b0, ZERO_DISP},
			'{OP_SPARE_HI, 32'hAAAA_AAAA,  4'd5,  1, 1'b0, ZERO_DISP},
			// Reset op empties the table yet keeps the current split.
			'{OP_RESET,    32'd1000,       4'd0,  1, 1'b0, ZERO_DISP},
			'{OP_READ,     32'd0,          4'd1,  1, 1'b0, ZERO_DISP},
			'{OP_UPDATE,   32'd3724456,    4'd0,  1, 1'b0, ZERO_DISP},
			// Seventeen laps in a row: the last finds the table full.
			'{OP_NEW_LAP,  32'd3724456,    4'd0, 17, 1'b0, ZERO_DISP}
		};
		foreach (plan[r])
			repeat (plan[r].reps)
				push_request(plan[r].op, plan[r].now, plan[r].idx,
					plan[r].typed, plan[r].disp);
		push_request(OP_READ, 32'hFFFF_FFFF, 4'd15);

		// Random part: mostly lap sessions with rising ticks, some stray and read-only beats.
		tick = $urandom;
		while (fed_beats < TOTAL_BEATS) begin
			if (fed_beats >= CALM_FROM) begin
				src_pct = 0;
				snk_pct = 0;
			end else begin
				src_pct = pick_pace();
				snk_pct = pick_pace();
			end
			kind = $urandom_range(0, 19);
			if (kind < 2) begin
				// Stray beat: any op, any tick, any index.
				push_request(3'($urandom_range(0, 7)), $urandom, 4'($urandom_range(0, 15)));
			end else if (kind == 2) begin
				repeat ($urandom_range(1, 6))
					push_request(OP_READ, $urandom, 4'($urandom_range(0, 15)));
			end else begin
				// Jump the tick now and then, sometimes just short of the wrap.
				if ($urandom_range(0, 3) == 0)
					tick = ($urandom_range(0, 1) == 0) ? $urandom
						: 32'hFFFF_FFFF - $urandom_range(0, 5000000);
				case ($urandom_range(0, 3))
					0:       push_request(OP_RESET, tick, 4'($urandom_range(0, 15)));
					1:       push_request(OP_INIT, tick, 4'($urandom_range(0, 15)));
					default: ;
				endcase
				repeat ($urandom_range(1, 20)) begin
					repeat ($urandom_range(0, 3)) begin
						case ($urandom_range(0, 9))
							0:       step = $urandom_range(0, 99);
							1, 2, 3,
							4, 5:    step = $urandom_range(0, 99999);
							6, 7:    step = $urandom_range(0, 10000000);
							8:       step = $urandom_range(0, 600000000);
							default: step = $urandom;
						endcase
						tick = tick + step;
						push_request(OP_UPDATE, tick, 4'($urandom_range(0, 15)));
					end
					if ($urandom_range(0, 5) == 0)
						push_request(OP_READ, $urandom, 4'($urandom_range(0, 15)));
					if ($urandom_range(0, 15) == 0)
						push_request(OP_INIT, tick, 4'($urandom_range(0, 15)));
					push_request(OP_NEW_LAP, tick, 4'($urandom_range(0, 15)));
				end
			end
		end

		// Drop valid and let the pipeline drain.
		req_if.valid <= 1'b0;
		while (owed_displays.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);

		$display("Drove %0d request beats (unknown ops not counted), compared %0d displays;",
			fed_beats, checked_beats);
		$display("a full lap table turned away %0d new-lap beats.", full_hits);
		if (fault_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
